>>> hdl/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg: shared types and constants of the segment intersection core
// Holds the default coordinate width and the control word that travels
// alongside the data through the geometry stages and the dividers.
// ----------------------------------------------------------------------------
package segi_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  typedef struct packed {
    logic vld;   // a word occupies this stage
    logic ok;    // the segments meet at a single point
    logic neg;   // the rounded quotient is negative
  } segi_ctl_t;

endpackage

>>> hdl/segment_intersection_point_core.sv
// ----------------------------------------------------------------------------
// segment_intersection_point_core: integer segment crossing point
// Tests two segments for a crossing and returns the rounded crossing point.
// ----------------------------------------------------------------------------
// Usage:
//   A word is two segments, A and B, as eight signed coordinates on the in_
//   ports. It is taken at a rising edge where start is high and busy is low.
//   busy stays low: the pipeline takes a new word in every cycle.
//   Each word yields exactly one result word, shown for a single cycle with
//   out_valid high. out_crosses tells whether the segments meet at one point;
//   out_cross_x and out_cross_y hold the point rounded to nearest, or zero.
//   A word passes through five stages of line equations and multipliers,
//   a divider input register, COORD_WIDTH + 1 divider stages that each
//   resolve one quotient bit, and one sign and output stage; throughput is
//   one word a cycle.
//   The receiver cannot stall, so results leave in input order, one per word.
//   Reset (rst_n low, synchronous) clears all valid bits; words in flight are
//   dropped and no result appears until new words are started.
// ----------------------------------------------------------------------------
module segment_intersection_point_core #(
  parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_seg_a_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_a_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_a_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_a_end_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_b_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_b_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_b_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_seg_b_end_y,
  output logic                          out_valid,
  output logic                          out_crosses,
  output logic signed [COORD_WIDTH-1:0] out_cross_x,
  output logic signed [COORD_WIDTH-1:0] out_cross_y
);
  import segi_pkg::*;

  // Numerator magnitude, absolute denominator and quotient widths. The
  // quotient gets one spare bit above the coordinate width.
  localparam int NW  = 3 * COORD_WIDTH + 4;
  localparam int DW  = 2 * COORD_WIDTH + 3;
  localparam int QW  = COORD_WIDTH + 1;
  localparam int LAT = COORD_WIDTH + 8;

  segi_ctl_t          geo_ctl_x, geo_ctl_y, div_ctl_x, div_ctl_y;
  logic [NW-1:0]      mag_x, mag_y;
  logic [DW-1:0]      den_abs;
  logic signed [COORD_WIDTH-1:0] quot_x, quot_y;
  logic               accept;

  // Nothing holds the pipeline back, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  segi_geom #(.W(COORD_WIDTH)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (accept),
    .x1        (in_seg_a_start_x),
    .y1        (in_seg_a_start_y),
    .x2        (in_seg_a_end_x),
    .y2        (in_seg_a_end_y),
    .x3        (in_seg_b_start_x),
    .y3        (in_seg_b_start_y),
    .x4        (in_seg_b_end_x),
    .y4        (in_seg_b_end_y),
    .out_ctl_x (geo_ctl_x),
    .out_ctl_y (geo_ctl_y),
    .out_mag_x (mag_x),
    .out_mag_y (mag_y),
    .out_den   (den_abs)
  );

  // Both coordinates share one denominator and divide side by side.
  segi_div #(.NW(NW), .DW(DW), .QW(QW), .OW(COORD_WIDTH)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (geo_ctl_x),
    .in_mag   (mag_x),
    .in_den   (den_abs),
    .out_ctl  (div_ctl_x),
    .out_quot (quot_x)
  );

  segi_div #(.NW(NW), .DW(DW), .QW(QW), .OW(COORD_WIDTH)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (geo_ctl_y),
    .in_mag   (mag_y),
    .in_den   (den_abs),
    .out_ctl  (div_ctl_y),
    .out_quot (quot_y)
  );

  // A rejected pair still runs through the divider; its point reads as zero.
  assign out_valid   = div_ctl_x.vld;
  assign out_crosses = div_ctl_x.ok;
  assign out_cross_x = div_ctl_x.ok ? quot_x : '0;
  assign out_cross_y = div_ctl_x.ok ? quot_y : '0;

  // Every result traces back to a matching start.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a matching start");

  // The two dividers stay in lock step; the verdicts only matter on a word.
  a_lock: assert property (@(posedge clk) disable iff (!rst_n)
    (div_ctl_x.vld == div_ctl_y.vld) &&
    (!div_ctl_x.vld || (div_ctl_x.ok == div_ctl_y.ok)))
    else $error("divider lanes out of step");

  // The verdict only means something on a valid result.
  a_cross_vld: assert property (@(posedge clk) disable iff (!rst_n)
    (out_crosses && !out_valid) |-> !$past(start, LAT))
    else $error("crossing flag set on an empty slot after a start");

endmodule

>>> hdl/segi_geom.sv
// ----------------------------------------------------------------------------
// segi_geom: line equations, side tests and numerators
// Five register stages that turn two segments into the magnitudes of the
// rounded numerators, the absolute denominator and the crossing verdict.
// ----------------------------------------------------------------------------
module segi_geom #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic signed [W-1:0]    x1,
  input  logic signed [W-1:0]    y1,
  input  logic signed [W-1:0]    x2,
  input  logic signed [W-1:0]    y2,
  input  logic signed [W-1:0]    x3,
  input  logic signed [W-1:0]    y3,
  input  logic signed [W-1:0]    x4,
  input  logic signed [W-1:0]    y4,
  output segi_pkg::segi_ctl_t    out_ctl_x,
  output segi_pkg::segi_ctl_t    out_ctl_y,
  output logic [3*W+3:0]         out_mag_x,
  output logic [3*W+3:0]         out_mag_y,
  output logic [2*W+2:0]         out_den
);
  import segi_pkg::*;

  localparam int LW  = W + 1;       // coefficient a or b
  localparam int PW  = 2 * W;       // coordinate product
  localparam int CW  = 2 * W + 1;   // constant term c, coefficient times coordinate
  localparam int PPW = 2 * W + 2;   // coefficient times coefficient or half of c
  localparam int SW  = 2 * W + 3;   // side values and denominator
  localparam int NW  = 3 * W + 4;   // numerators

  // Stage 1
  logic              s1_vld_r;
  logic signed [LW-1:0] s1_la_r, s1_lb_r, s1_ma_r, s1_mb_r;
  logic signed [PW-1:0] s1_p21_r, s1_p12_r, s1_p43_r, s1_p34_r;
  logic signed [W-1:0]  s1_x1_r, s1_y1_r, s1_x2_r, s1_y2_r;
  logic signed [W-1:0]  s1_x3_r, s1_y3_r, s1_x4_r, s1_y4_r;
  // Stage 2
  logic              s2_vld_r;
  logic signed [CW-1:0]  s2_lc_r, s2_mc_r;
  logic signed [CW-1:0]  s2_ax3_r, s2_by3_r, s2_ax4_r, s2_by4_r;
  logic signed [CW-1:0]  s2_ax1_r, s2_by1_r, s2_ax2_r, s2_by2_r;
  logic signed [PPW-1:0] s2_d0_r, s2_d1_r;
  logic signed [LW-1:0]  s2_la_r, s2_lb_r, s2_ma_r, s2_mb_r;
  // Stage 3
  logic              s3_vld_r;
  logic signed [SW-1:0]  s3_s1_r, s3_s2_r, s3_s3_r, s3_s4_r, s3_den_r;
  logic signed [PPW-1:0] s3_lbh_r, s3_lbl_r, s3_mbh_r, s3_mbl_r;
  logic signed [PPW-1:0] s3_mah_r, s3_mal_r, s3_lah_r, s3_lal_r;
  // Stage 4
  logic              s4_vld_r, s4_ok_r, s4_dneg_r;
  logic signed [NW-1:0] s4_nx_r, s4_ny_r;
  logic [SW-1:0]     s4_dabs_r;
  // Stage 5
  logic              s5_vld_r, s5_ok_r, s5_negx_r, s5_negy_r;
  logic [NW-1:0]     s5_magx_r, s5_magy_r;
  logic [SW-1:0]     s5_den_r;

  logic signed [LW-1:0] lc_hi, lc_lo, mc_hi, mc_lo;
  logic ss_a, ss_b;
  logic [NW-1:0] absx, absy;

  always_comb begin
    lc_hi = $signed(s2_lc_r[CW-1:W]);
    lc_lo = $signed({1'b0, s2_lc_r[W-1:0]});
    mc_hi = $signed(s2_mc_r[CW-1:W]);
    mc_lo = $signed({1'b0, s2_mc_r[W-1:0]});
    // Strictly on one side: both side values nonzero with equal sign.
    ss_a = (s3_s3_r != '0) && (s3_s4_r != '0) && (s3_s3_r[SW-1] == s3_s4_r[SW-1]);
    ss_b = (s3_s1_r != '0) && (s3_s2_r != '0) && (s3_s1_r[SW-1] == s3_s2_r[SW-1]);
    absx = s4_nx_r[NW-1] ? NW'(-s4_nx_r) : NW'(s4_nx_r);
    absy = s4_ny_r[NW-1] ? NW'(-s4_ny_r) : NW'(s4_ny_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_la_r  <= LW'(y2) - LW'(y1);
    s1_lb_r  <= LW'(x1) - LW'(x2);
    s1_ma_r  <= LW'(y4) - LW'(y3);
    s1_mb_r  <= LW'(x3) - LW'(x4);
    s1_p21_r <= PW'(x2) * PW'(y1);
    s1_p12_r <= PW'(x1) * PW'(y2);
    s1_p43_r <= PW'(x4) * PW'(y3);
    s1_p34_r <= PW'(x3) * PW'(y4);
    s1_x1_r  <= x1;
    s1_y1_r  <= y1;
    s1_x2_r  <= x2;
    s1_y2_r  <= y2;
    s1_x3_r  <= x3;
    s1_y3_r  <= y3;
    s1_x4_r  <= x4;
    s1_y4_r  <= y4;

    s2_lc_r  <= CW'(s1_p21_r) - CW'(s1_p12_r);
    s2_mc_r  <= CW'(s1_p43_r) - CW'(s1_p34_r);
    s2_ax3_r <= CW'(s1_la_r) * CW'(s1_x3_r);
    s2_by3_r <= CW'(s1_lb_r) * CW'(s1_y3_r);
    s2_ax4_r <= CW'(s1_la_r) * CW'(s1_x4_r);
    s2_by4_r <= CW'(s1_lb_r) * CW'(s1_y4_r);
    s2_ax1_r <= CW'(s1_ma_r) * CW'(s1_x1_r);
    s2_by1_r <= CW'(s1_mb_r) * CW'(s1_y1_r);
    s2_ax2_r <= CW'(s1_ma_r) * CW'(s1_x2_r);
    s2_by2_r <= CW'(s1_mb_r) * CW'(s1_y2_r);
    s2_d0_r  <= PPW'(s1_la_r) * PPW'(s1_mb_r);
    s2_d1_r  <= PPW'(s1_ma_r) * PPW'(s1_lb_r);
    s2_la_r  <= s1_la_r;
    s2_lb_r  <= s1_lb_r;
    s2_ma_r  <= s1_ma_r;
    s2_mb_r  <= s1_mb_r;

    s3_s3_r  <= SW'(s2_ax3_r) + SW'(s2_by3_r) + SW'(s2_lc_r);
    s3_s4_r  <= SW'(s2_ax4_r) + SW'(s2_by4_r) + SW'(s2_lc_r);
    s3_s1_r  <= SW'(s2_ax1_r) + SW'(s2_by1_r) + SW'(s2_mc_r);
    s3_s2_r  <= SW'(s2_ax2_r) + SW'(s2_by2_r) + SW'(s2_mc_r);
    s3_den_r <= SW'(s2_d0_r) - SW'(s2_d1_r);
    // The constant terms are split in halves to keep each multiplier small.
    s3_lbh_r <= PPW'(s2_lb_r) * PPW'(mc_hi);
    s3_lbl_r <= PPW'(s2_lb_r) * PPW'(mc_lo);
    s3_mbh_r <= PPW'(s2_mb_r) * PPW'(lc_hi);
    s3_mbl_r <= PPW'(s2_mb_r) * PPW'(lc_lo);
    s3_mah_r <= PPW'(s2_ma_r) * PPW'(lc_hi);
    s3_mal_r <= PPW'(s2_ma_r) * PPW'(lc_lo);
    s3_lah_r <= PPW'(s2_la_r) * PPW'(mc_hi);
    s3_lal_r <= PPW'(s2_la_r) * PPW'(mc_lo);

    s4_ok_r   <= !ss_a && !ss_b && (s3_den_r != '0);
    s4_dneg_r <= s3_den_r[SW-1];
    s4_dabs_r <= s3_den_r[SW-1] ? SW'(-s3_den_r) : SW'(s3_den_r);
    s4_nx_r   <= ((NW'(s3_lbh_r) - NW'(s3_mbh_r)) <<< W) + NW'(s3_lbl_r) - NW'(s3_mbl_r);
    s4_ny_r   <= ((NW'(s3_mah_r) - NW'(s3_lah_r)) <<< W) + NW'(s3_mal_r) - NW'(s3_lal_r);

    // Rounding adds half the denominator away from zero.
    s5_ok_r   <= s4_ok_r;
    s5_negx_r <= s4_nx_r[NW-1] ^ s4_dneg_r;
    s5_negy_r <= s4_ny_r[NW-1] ^ s4_dneg_r;
    s5_magx_r <= absx + NW'(s4_dabs_r >> 1);
    s5_magy_r <= absy + NW'(s4_dabs_r >> 1);
    s5_den_r  <= s4_dabs_r;
  end

  assign out_ctl_x = '{vld: s5_vld_r, ok: s5_ok_r, neg: s5_negx_r};
  assign out_ctl_y = '{vld: s5_vld_r, ok: s5_ok_r, neg: s5_negy_r};
  assign out_mag_x = s5_magx_r;
  assign out_mag_y = s5_magy_r;
  assign out_den   = s5_den_r;

endmodule

>>> hdl/segi_div.sv
// ----------------------------------------------------------------------------
// segi_div: pipelined restoring divider
// One quotient bit per stage, then sign correction into the output register.
// ----------------------------------------------------------------------------
module segi_div #(
  parameter int NW = 52,
  parameter int DW = 35,
  parameter int QW = 17,
  parameter int OW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  segi_pkg::segi_ctl_t  in_ctl,
  input  logic [NW-1:0]        in_mag,
  input  logic [DW-1:0]        in_den,
  output segi_pkg::segi_ctl_t  out_ctl,
  output logic signed [OW-1:0] out_quot
);
  import segi_pkg::*;

  segi_ctl_t         ctl_r [0:QW];
  logic [NW-1:0]     rem_r [0:QW];
  logic [DW-1:0]     den_r [0:QW];
  logic [QW-1:0]     q_r   [0:QW];
  segi_ctl_t         out_ctl_r;
  logic [OW-1:0]     quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].vld <= 1'b0;
    end else begin
      ctl_r[0].vld <= in_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0].ok  <= in_ctl.ok;
    ctl_r[0].neg <= in_ctl.neg;
    rem_r[0]     <= in_mag;
    den_r[0]     <= in_den;
    q_r[0]       <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] trial;
    logic          ge;
    assign trial = NW'(den_r[k]) << (QW - 1 - k);
    assign ge    = rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1].vld <= 1'b0;
      end else begin
        ctl_r[k+1].vld <= ctl_r[k].vld;
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[k+1].ok  <= ctl_r[k].ok;
      ctl_r[k+1].neg <= ctl_r[k].neg;
      rem_r[k+1]     <= ge ? rem_r[k] - trial : rem_r[k];
      den_r[k+1]     <= den_r[k];
      q_r[k+1]       <= {q_r[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ctl_r.vld <= 1'b0;
    end else begin
      out_ctl_r.vld <= ctl_r[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl_r.ok  <= ctl_r[QW].ok;
    out_ctl_r.neg <= ctl_r[QW].neg;
    quot_r        <= ctl_r[QW].neg ? OW'(-q_r[QW]) : OW'(q_r[QW]);
  end

  assign out_ctl  = out_ctl_r;
  assign out_quot = $signed(quot_r);

endmodule
